@@ hdl/sli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg: shared types and codes for the sorted list block
// Command and status bundles between the controller and the datapath,
// and the request operation codes.
// ----------------------------------------------------------------------------
package sli_pkg;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture the request value
      logic ins;     // shift in the held value at its ordered place
      logic rem;     // close the gap at the first matching entry
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;    // count has reached capacity
      logic found;   // held value sits at its ordered place
   } sts_type;

endpackage

@@ hdl/sli_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ctrl: request sequencer
// Takes a request, holds its operation, decides in the execute cycle
// whether the datapath shifts, and strobes the response.
// ----------------------------------------------------------------------------
module sli_ctrl
   import sli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  logic    req_operation,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    rsp_strobe,
   output logic    rsp_success
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic op_ff, op_in;
   logic strobe_ff, strobe_in;
   logic success_ff, success_in;

   assign busy = (state_ff == S_EXEC);

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      strobe_in  = 1'b0;
      success_in = success_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.ins    = (op_ff == OP_INSERT) && !sts.full;
            cmd.rem    = (op_ff == OP_REMOVE) && sts.found;
            success_in = cmd.ins || cmd.rem;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // held operation and response flag
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      success_ff <= success_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_success = success_ff;

endmodule

@@ hdl/sli_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_dpath: sorted entry chain
// A row of cells compares every entry against the held value at once and
// shifts up on insert or down on remove; keeps the entry count.
// ----------------------------------------------------------------------------
module sli_dpath
   import sli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] req_value,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_is_empty
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [31:0] cell_ff [CAPACITY];
   logic signed [31:0] cell_in [CAPACITY];
   logic signed [31:0] value_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CAPACITY-1:0] valid, lt, bound, hit;
   logic [CW+4:0]      count_ext;

   // per-cell compare against the held value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign valid[i] = count_ff > CW'(i);
      assign lt[i]    = valid[i] && (cell_ff[i] < value_ff);
      if (i == 0) begin : g_first
         assign bound[i] = !lt[i];
      end else begin : g_rest
         assign bound[i] = !lt[i] && lt[i-1];
      end
      assign hit[i] = bound[i] && valid[i] && (cell_ff[i] == value_ff);
   end

   assign sts.full  = (count_ff == CW'(CAPACITY));
   assign sts.found = |hit;

   // per-cell next value: keep below the place, shift above it
   for (genvar i = 0; i < CAPACITY; i++) begin : g_next
      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.ins && !lt[i]) begin
            if (bound[i]) begin
               cell_in[i] = value_ff;
            end else if (i > 0) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.rem && !lt[i] && (i + 1 < CAPACITY)) begin
            cell_in[i] = cell_ff[(i + 1 < CAPACITY) ? i + 1 : i];
         end
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.rem) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entries and held value carry no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
      for (int k = 0; k < CAPACITY; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   assign count_ext       = {5'b0, count_ff};
   assign rsp_entry_count = count_ext[4:0];
   assign rsp_is_empty    = (count_ff == '0);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.rem))
      else $error("insert and remove in one cycle");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |-> !sts.full)
      else $error("insert into a full list");

   a_rem_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not drop the count");

endmodule

@@ hdl/sorted_list_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: bounded sorted multiset of signed words
// Response: a request taken in the idle state moves the sequencer to its
//   execute state, which sets the strobe register behind the rsp_ ports,
//   high for one cycle; the receiver cannot stall. start is ignored while
//   busy, in the execute state, in which all cells compare and shift at once.
// Reset clears the count and the sequencer; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove
   import sli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic               rsp_success,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_is_empty
);

   cmd_type cmd;
   sts_type sts;

   sli_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .rsp_strobe    (rsp_strobe),
      .rsp_success   (rsp_success)
   );

   sli_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
